// ===== sv/eevdf_rq_pkg.sv =====
package eevdf_rq_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 64;

   localparam logic [2:0] MODE_INSERT  = 3'd0;
   localparam logic [2:0] MODE_REMOVE  = 3'd1;
   localparam logic [2:0] MODE_SET_RUN = 3'd2;
   localparam logic [2:0] MODE_CHARGE  = 3'd3;
   localparam logic [2:0] MODE_PICK    = 3'd4;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;
   localparam logic [1:0] STATUS_IGNORED = 2'd3;

   localparam int unsigned DIVIDEND_W = 43;
   localparam int unsigned DIVISOR_W  = 21;

   localparam logic [13:0] UNIT_WEIGHT = 14'd1024;
   localparam logic [3:0]  SLICE_RESET = 4'd5;
   localparam logic [3:0]  SLICE_MIN   = 4'd2;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] thread_id;
      logic [13:0] weight;
      logic [63:0] vruntime;
      logic [12:0] vruntime_remainder;
      logic        runnable;
      logic [31:0] elapsed_ms;
      logic        is_idle;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] picked_id;
      logic [13:0] picked_weight;
      logic [63:0] new_vruntime;
      logic [12:0] new_remainder;
      logic [63:0] picked_deadline;
      logic [63:0] average_vruntime;
   } rsp_type;

   typedef struct packed {
      logic [15:0] id;
      logic [13:0] weight;
      logic [63:0] vruntime;
      logic [12:0] remainder;
      logic [63:0] deadline;
      logic        runnable;
   } entry_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

   function automatic logic ranks_before(input logic [63:0] a_dl, input logic [15:0] a_id,
                                         input logic [63:0] b_dl, input logic [15:0] b_id);
      logic r;
      if (a_dl != b_dl) begin
         r = (a_dl < b_dl);
      end else begin
         r = (a_id < b_id);
      end
      return r;
   endfunction

endpackage

// ===== sv/eevdf_run_queue_unit.sv =====
// Channel   Ports                                   Transfer
// request   start, busy, req_data                   start high and busy low at the edge
// result    rsp_valid, rsp_data                     one cycle with rsp_valid high
// config    csr_write_enable, csr_write_data        edge with csr_write_enable high
//
// Insert, remove, set runnable and pick walk the table one entry a cycle through
// its single read port.
// Charge runs two 43-step divisions on the shared radix-2 divider.
// An idle charge or an unknown mode is answered without a table walk or a division.
// Synchronous reset empties the queue at once; no clearing pass.
// The result strobe lasts one cycle and cannot be stalled.
module eevdf_run_queue_unit #(
   parameter int unsigned QUEUE_DEPTH = eevdf_rq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  eevdf_rq_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output eevdf_rq_pkg::rsp_type  rsp_data,
   input  logic                   csr_write_enable,
   input  logic [3:0]             csr_write_data
);

   localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_INS_A = 4'd2;
   localparam logic [3:0] S_INS_B = 4'd3;
   localparam logic [3:0] S_INS_C = 4'd4;
   localparam logic [3:0] S_FIN   = 4'd5;
   localparam logic [3:0] S_D1S   = 4'd6;
   localparam logic [3:0] S_D1W   = 4'd7;
   localparam logic [3:0] S_D2S   = 4'd8;
   localparam logic [3:0] S_D2W   = 4'd9;
   localparam logic [3:0] S_IDLE_CHG = 4'd10;

   logic [3:0]                state_ff, state_in;
   eevdf_rq_pkg::req_type     req_ff, req_in;
   logic [3:0]                slice_ff, slice_in;
   logic [QUEUE_DEPTH-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [19:0]               total_ff, total_in;
   logic [63:0]               avg_ff, avg_in;
   logic [19:0]               avg_rem_ff, avg_rem_in;
   logic [CNT_W-1:0]          scan_ff, scan_in;
   logic                      chk_ff, chk_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic                      match_ff, match_in;
   logic [IDX_W-1:0]          match_idx_ff, match_idx_in;
   eevdf_rq_pkg::entry_type   match_rec_ff, match_rec_in;
   logic                      free_ff, free_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic                      be_ff, be_in;
   logic [IDX_W-1:0]          be_idx_ff, be_idx_in;
   eevdf_rq_pkg::entry_type   be_rec_ff, be_rec_in;
   logic                      ba_ff, ba_in;
   logic [IDX_W-1:0]          ba_idx_ff, ba_idx_in;
   eevdf_rq_pkg::entry_type   ba_rec_ff, ba_rec_in;
   logic [63:0]               low_ff, low_in;
   logic [63:0]               high_ff, high_in;
   logic [63:0]               clamp_vr_ff, clamp_vr_in;
   logic [12:0]               clamp_rem_ff, clamp_rem_in;
   logic [eevdf_rq_pkg::DIVIDEND_W-1:0] q1_ff, q1_in;
   logic [12:0]               r1_ff, r1_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   eevdf_rq_pkg::rsp_type     rsp_ff, rsp_in;

   logic                      tbl_we;
   logic [IDX_W-1:0]          tbl_waddr;
   eevdf_rq_pkg::entry_type   tbl_wdata;
   logic [IDX_W-1:0]          tbl_raddr;
   eevdf_rq_pkg::entry_type   ent;
   eevdf_rq_pkg::div_req_type div_req;
   eevdf_rq_pkg::div_rsp_type div_rsp;

   logic [3:0]                slice;
   logic [13:0]               chg_w;
   logic [31:0]               chg_delta;
   logic [42:0]               chg_sum;
   logic [42:0]               chg_asum;
   logic [20:0]               chg_active;
   logic [42:0]               idle_sum;
   logic                      take;
   logic [IDX_W-1:0]          take_idx;
   eevdf_rq_pkg::entry_type   take_rec;

   eevdf_rq_table #(.DEPTH(QUEUE_DEPTH), .IDX_W(IDX_W)) u_table (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (ent)
   );

   eevdf_rq_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      slice      = (slice_ff < eevdf_rq_pkg::SLICE_MIN) ? eevdf_rq_pkg::SLICE_MIN : slice_ff;
      chg_w      = (req_ff.weight != 14'd0) ? req_ff.weight : eevdf_rq_pkg::UNIT_WEIGHT;
      chg_delta  = (req_ff.elapsed_ms != 32'd0) ? req_ff.elapsed_ms : 32'd1;
      chg_sum    = {1'b0, chg_delta, 10'd0} + 43'(req_ff.vruntime_remainder);
      chg_asum   = {1'b0, chg_delta, 10'd0} + 43'(avg_rem_ff);
      chg_active = 21'(total_ff) + 21'(chg_w);
      idle_sum   = {1'b0, req_ff.elapsed_ms, 10'd0} + 43'(avg_rem_ff);
      tbl_raddr  = scan_ff[IDX_W-1:0];

      state_in     = state_ff;
      req_in       = req_ff;
      slice_in     = csr_write_enable ? csr_write_data : slice_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      avg_in       = avg_ff;
      avg_rem_in   = avg_rem_ff;
      scan_in      = scan_ff;
      chk_in       = 1'b0;
      chk_idx_in   = scan_ff[IDX_W-1:0];
      chk_vld_in   = valid_ff[scan_ff[IDX_W-1:0]];
      match_in     = match_ff;
      match_idx_in = match_idx_ff;
      match_rec_in = match_rec_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      be_in        = be_ff;
      be_idx_in    = be_idx_ff;
      be_rec_in    = be_rec_ff;
      ba_in        = ba_ff;
      ba_idx_in    = ba_idx_ff;
      ba_rec_in    = ba_rec_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      clamp_vr_in  = clamp_vr_ff;
      clamp_rem_in = clamp_rem_ff;
      q1_in        = q1_ff;
      r1_in        = r1_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      tbl_we       = 1'b0;
      tbl_waddr    = match_idx_ff;
      tbl_wdata    = match_rec_ff;
      div_req.start    = 1'b0;
      div_req.dividend = chg_sum;
      div_req.divisor  = 21'(chg_w);
      take     = 1'b0;
      take_idx = match_idx_ff;
      take_rec = match_rec_ff;

      rsp_in.status           = eevdf_rq_pkg::STATUS_DONE;
      rsp_in.picked_id        = req_ff.thread_id;
      rsp_in.picked_weight    = '0;
      rsp_in.new_vruntime     = '0;
      rsp_in.new_remainder    = '0;
      rsp_in.picked_deadline  = '0;
      rsp_in.average_vruntime = avg_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               scan_in  = '0;
               match_in = 1'b0;
               free_in  = 1'b0;
               be_in    = 1'b0;
               ba_in    = 1'b0;
               case (req_data.mode)
                  eevdf_rq_pkg::MODE_INSERT,
                  eevdf_rq_pkg::MODE_REMOVE,
                  eevdf_rq_pkg::MODE_SET_RUN,
                  eevdf_rq_pkg::MODE_PICK: state_in = S_SCAN;
                  eevdf_rq_pkg::MODE_CHARGE: state_in = req_data.is_idle ? S_IDLE_CHG : S_D1S;
                  default: begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.status    = eevdf_rq_pkg::STATUS_IGNORED;
                     rsp_in.picked_id = req_data.thread_id;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff < CNT_W'(QUEUE_DEPTH)) begin
               chk_in  = 1'b1;
               scan_in = scan_ff + 1'b1;
            end
            if (chk_ff) begin
               if (chk_vld_ff && ent.id == req_ff.thread_id && !match_ff) begin
                  match_in     = 1'b1;
                  match_idx_in = chk_idx_ff;
                  match_rec_in = ent;
               end
               if (!chk_vld_ff && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = chk_idx_ff;
               end
               if (chk_vld_ff && ent.runnable) begin
                  if (ent.vruntime <= avg_ff && (!be_ff || eevdf_rq_pkg::ranks_before(
                        ent.deadline, ent.id, be_rec_ff.deadline, be_rec_ff.id))) begin
                     be_in     = 1'b1;
                     be_idx_in = chk_idx_ff;
                     be_rec_in = ent;
                  end
                  if (!ba_ff || eevdf_rq_pkg::ranks_before(
                        ent.deadline, ent.id, ba_rec_ff.deadline, ba_rec_ff.id)) begin
                     ba_in     = 1'b1;
                     ba_idx_in = chk_idx_ff;
                     ba_rec_in = ent;
                  end
               end
               if (chk_idx_ff == IDX_W'(QUEUE_DEPTH - 1)) begin
                  state_in = (req_ff.mode == eevdf_rq_pkg::MODE_INSERT) ? S_INS_A : S_FIN;
               end
            end
         end
         S_INS_A: begin
            if (match_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = eevdf_rq_pkg::STATUS_IGNORED;
               state_in      = S_IDLE;
            end else if (!free_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = eevdf_rq_pkg::STATUS_FULL;
               state_in      = S_IDLE;
            end else begin
               low_in   = (avg_ff > 64'(slice)) ? avg_ff - 64'(slice) : 64'd0;
               high_in  = avg_ff + 64'({slice, 1'b0});
               state_in = S_INS_B;
            end
         end
         S_INS_B: begin
            clamp_vr_in  = req_ff.vruntime;
            clamp_rem_in = req_ff.vruntime_remainder;
            if (req_ff.vruntime < low_ff) begin
               clamp_vr_in  = low_ff;
               clamp_rem_in = '0;
            end else if (req_ff.vruntime > high_ff) begin
               clamp_vr_in  = high_ff;
               clamp_rem_in = '0;
            end
            state_in = S_INS_C;
         end
         S_INS_C: begin
            tbl_we             = 1'b1;
            tbl_waddr          = free_idx_ff;
            tbl_wdata.id       = req_ff.thread_id;
            tbl_wdata.weight   = req_ff.weight;
            tbl_wdata.vruntime = clamp_vr_ff;
            tbl_wdata.remainder = clamp_rem_ff;
            tbl_wdata.deadline = clamp_vr_ff + 64'(slice);
            tbl_wdata.runnable = req_ff.runnable;
            valid_in[free_idx_ff] = 1'b1;
            count_in     = count_ff + 1'b1;
            total_in     = total_ff + 20'(req_ff.weight);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_FIN: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            case (req_ff.mode)
               eevdf_rq_pkg::MODE_REMOVE: begin
                  if (match_ff) begin
                     take = 1'b1;
                  end else begin
                     rsp_in.status = eevdf_rq_pkg::STATUS_IGNORED;
                  end
               end
               eevdf_rq_pkg::MODE_SET_RUN: begin
                  if (match_ff) begin
                     tbl_we             = 1'b1;
                     tbl_wdata.runnable = req_ff.runnable;
                  end else begin
                     rsp_in.status = eevdf_rq_pkg::STATUS_IGNORED;
                  end
               end
               default: begin
                  if (be_ff) begin
                     take     = 1'b1;
                     take_idx = be_idx_ff;
                     take_rec = be_rec_ff;
                  end else if (ba_ff) begin
                     take     = 1'b1;
                     take_idx = ba_idx_ff;
                     take_rec = ba_rec_ff;
                  end else begin
                     rsp_in.status = eevdf_rq_pkg::STATUS_EMPTY;
                  end
               end
            endcase
            if (take) begin
               valid_in[take_idx]     = 1'b0;
               count_in               = count_ff - 1'b1;
               total_in               = total_ff - 20'(take_rec.weight);
               rsp_in.picked_id       = take_rec.id;
               rsp_in.picked_weight   = take_rec.weight;
               rsp_in.new_vruntime    = take_rec.vruntime;
               rsp_in.new_remainder   = take_rec.remainder;
               rsp_in.picked_deadline = take_rec.deadline;
            end
         end
         S_D1S: begin
            div_req.start = 1'b1;
            state_in      = S_D1W;
         end
         S_D1W: begin
            if (div_rsp.done) begin
               q1_in    = div_rsp.quotient;
               r1_in    = div_rsp.remainder[12:0];
               state_in = S_D2S;
            end
         end
         S_D2S: begin
            div_req.start    = 1'b1;
            div_req.dividend = chg_asum;
            div_req.divisor  = chg_active;
            state_in         = S_D2W;
         end
         S_D2W: begin
            if (div_rsp.done) begin
               avg_in     = avg_ff + 64'(div_rsp.quotient);
               avg_rem_in = div_rsp.remainder[19:0];
               rsp_valid_in          = 1'b1;
               rsp_in.new_vruntime   = req_ff.vruntime + 64'(q1_ff);
               rsp_in.new_remainder  = r1_ff;
               rsp_in.average_vruntime = avg_ff + 64'(div_rsp.quotient);
               state_in   = S_IDLE;
            end
         end
         S_IDLE_CHG: begin
            if (req_ff.elapsed_ms != 32'd0) begin
               avg_in     = avg_ff + 64'(idle_sum[42:10]);
               avg_rem_in = {10'd0, idle_sum[9:0]};
               rsp_in.average_vruntime = avg_ff + 64'(idle_sum[42:10]);
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         slice_ff     <= eevdf_rq_pkg::SLICE_RESET;
         valid_ff     <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         avg_ff       <= '0;
         avg_rem_ff   <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slice_ff     <= slice_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         avg_ff       <= avg_in;
         avg_rem_ff   <= avg_rem_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      scan_ff      <= scan_in;
      chk_idx_ff   <= chk_idx_in;
      chk_vld_ff   <= chk_vld_in;
      match_ff     <= match_in;
      match_idx_ff <= match_idx_in;
      match_rec_ff <= match_rec_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      be_ff        <= be_in;
      be_idx_ff    <= be_idx_in;
      be_rec_ff    <= be_rec_in;
      ba_ff        <= ba_in;
      ba_idx_ff    <= ba_idx_in;
      ba_rec_ff    <= ba_rec_in;
      low_ff       <= low_in;
      high_ff      <= high_in;
      clamp_vr_ff  <= clamp_vr_in;
      clamp_rem_ff <= clamp_rem_in;
      q1_ff        <= q1_in;
      r1_ff        <= r1_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== sv/eevdf_rq_table.sv =====
module eevdf_rq_table #(
   parameter int unsigned DEPTH = eevdf_rq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int unsigned IDX_W = $clog2(DEPTH)
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [IDX_W-1:0]         wr_addr,
   input  eevdf_rq_pkg::entry_type  wr_data,
   input  logic [IDX_W-1:0]         rd_addr,
   output eevdf_rq_pkg::entry_type  rd_data
);

   eevdf_rq_pkg::entry_type mem [DEPTH];
   eevdf_rq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/eevdf_rq_divider.sv =====
module eevdf_rq_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  eevdf_rq_pkg::div_req_type  div_req,
   output eevdf_rq_pkg::div_rsp_type  div_rsp
);

   localparam int unsigned N     = eevdf_rq_pkg::DIVIDEND_W;
   localparam int unsigned D     = eevdf_rq_pkg::DIVISOR_W;
   localparam int unsigned CNT_W = $clog2(N + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [N-1:0]     quo_ff, quo_in;
   logic [D-1:0]     rem_ff, rem_in;
   logic [D-1:0]     dvs_ff, dvs_in;
   logic [D:0]       trial;
   logic [D:0]       diff;
   logic             ge;

   always_comb begin
      trial = {rem_ff, quo_ff[N-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      if (active_ff) begin
         quo_in = {quo_ff[N-2:0], ge};
         rem_in = ge ? diff[D-1:0] : trial[D-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(N - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end else if (div_req.start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = div_req.dividend;
         rem_in    = '0;
         dvs_in    = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== sv/eevdf_rq_checker.sv =====
module eevdf_rq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input eevdf_rq_pkg::req_type  req_data,
   input logic                   rsp_valid,
   input eevdf_rq_pkg::rsp_type  rsp_data
);

   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start || busy))
      else $error("result without a transfer in progress");

   a_start_takes: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted request neither busy nor answered");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   a_done_answers: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("operation ended without a result");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == eevdf_rq_pkg::STATUS_EMPTY
      |-> rsp_data.picked_weight == 14'd0 && rsp_data.picked_deadline == 64'd0)
      else $error("empty pick carries entry data");

endmodule

bind eevdf_run_queue_unit eevdf_rq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
